// ----- design/grc_pkg.sv -----
// Shared constants, types and the sine table builder for the raycast column renderer.
`timescale 1ns / 1ps
package grc_pkg;

    // Map geometry, fixed by the 16-bit wall row and 4-bit row index
    localparam int MAP_SIDE   = 16;
    localparam int MAP_BITS   = 4;
    localparam int POS_FRAC   = 12;
    localparam int DIST_W     = 13;
    localparam logic [DIST_W-1:0] MARCH_LIMIT = DIST_W'(MAP_SIDE * 256);

    // Trig table: one entry per 16 angle units, Q1.14 signed in 16 bits
    localparam int TRIG_DEPTH = 256;
    localparam int TRIG_BITS  = 8;
    localparam int TRIG_W     = 16;

    // Screen rows
    localparam int MAX_ROWS   = 64;
    localparam int ROWS_W     = 7;
    localparam int ROW_W      = 6;

    // Shared divider geometry
    localparam int DIV_NUM_W  = 20;
    localparam int DIV_DEN_W  = 14;
    localparam int DIV_CNT_W  = 5;

    // Input commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_CAST = 1'b1;

    // Shade codes
    localparam logic [3:0] SHADE_BLANK  = 4'd0;
    localparam logic [3:0] SHADE_FULL   = 4'd1;
    localparam logic [3:0] SHADE_DARK   = 4'd2;
    localparam logic [3:0] SHADE_MEDIUM = 4'd3;
    localparam logic [3:0] SHADE_LIGHT  = 4'd4;
    localparam logic [3:0] SHADE_PLUS   = 4'd5;
    localparam logic [3:0] SHADE_EQUALS = 4'd6;
    localparam logic [3:0] SHADE_DASH   = 4'd7;
    localparam logic [3:0] SHADE_DOT    = 4'd8;

    // Register indexes
    localparam logic [2:0] REG_ROWS   = 3'd0;
    localparam logic [2:0] REG_COLS   = 3'd1;
    localparam logic [2:0] REG_FOV    = 3'd2;
    localparam logic [2:0] REG_STEP   = 3'd3;
    localparam logic [2:0] REG_NEAR   = 3'd4;
    localparam logic [2:0] REG_MIDDLE = 3'd5;
    localparam logic [2:0] REG_FAR    = 3'd6;

    typedef struct packed {
        logic [6:0]  screen_rows;
        logic [7:0]  screen_columns;
        logic [11:0] field_of_view;
        logic [7:0]  march_step;
        logic [12:0] near_limit;
        logic [12:0] middle_limit;
        logic [12:0] far_limit;
    } cfg_t;

    typedef struct packed {
        logic load_map;
        logic load_cast;
        logic div_start;
        logic div_ceil;
        logic take_angle;
        logic take_trig;
        logic take_inc;
        logic march_adv;
        logic take_num;
        logic take_ceil;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic march_stop;
        logic rows_zero;
        logic row_last;
    } sts_t;

    typedef logic [TRIG_DEPTH*TRIG_W-1:0] sine_tab_t;

    // Build the signed sine table from the folded odd polynomial
    function automatic sine_tab_t build_sine_tab();
        sine_tab_t tab;
        longint ph;
        longint quad;
        longint r;
        longint z;
        longint z2;
        longint s;
        longint y;
        int p;
        tab = '0;
        for (p = 0; p < TRIG_DEPTH; p++) begin
            ph = longint'(p) << (16 - TRIG_BITS);
            quad = (ph >> 14) & 64'sd3;
            r = ph & 64'sd16383;
            if (quad[0]) begin
                r = 64'sd16384 - r;
            end
            z = r * 4;
            z2 = (z * z) >>> 16;
            s = 11;
            s = -307 + ((z2 * s) >>> 16);
            s = 5223 + ((z2 * s) >>> 16);
            s = -42334 + ((z2 * s) >>> 16);
            s = 102944 + ((z2 * s) >>> 16);
            y = (z * s) >>> 18;
            if (y > 16384) begin
                y = 16384;
            end
            if (y < 0) begin
                y = 0;
            end
            if (quad[1]) begin
                y = -y;
            end
            tab[p*TRIG_W +: TRIG_W] = TRIG_W'(y);
        end
        return tab;
    endfunction

endpackage

// ----- design/grid_raycast_column_renderer_unit.sv -----
// Top level: configuration registers, controller and datapath of the raycast renderer.
`timescale 1ns / 1ps
// Usage:
//   item channel (item_valid/item_ready): command 0 loads one 16-cell map row
//   (map_row, wall_bits) and produces no beat; command 1 casts one screen column
//   from player_x/player_y (Q4.12), view_angle and screen_column.
//   shade channel (shade_valid/shade_ready): one beat per screen row, row 0 first,
//   with row_number, shade_code, ray_distance, wall_found; last_row marks the end.
//   APB port: registers at 4*i, written on psel & penable & pwrite; pready is high.
// A cast is taken in, then runs the angle divide, trig lookup, step set-up, ray march
//   (until a wall, the map edge or distance 4096), ceiling product and ceiling divide
//   before the first beat; then one row per cycle while the receiver takes beats.
//   Both divides run on one shared bit-serial divider, whose done flag is registered
//   from its last iteration. After a load the block is ready for the next item.
//   One item is in work at a time; the next item is taken once the last row sits in
//   the output register.
// Reset: map cleared to all open, registers to their defaults, no beat pending.
// Stall: while shade_ready is low the current beat holds and row emission pauses.
module grid_raycast_column_renderer_unit (
    input  logic        clk,
    input  logic        rst_n,
    // item channel
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        command,
    input  logic [3:0]  map_row,
    input  logic [15:0] wall_bits,
    input  logic [15:0] player_x,
    input  logic [15:0] player_y,
    input  logic [11:0] view_angle,
    input  logic [7:0]  screen_column,
    // shade channel
    output logic        shade_valid,
    input  logic        shade_ready,
    output logic [5:0]  row_number,
    output logic [3:0]  shade_code,
    output logic [12:0] ray_distance,
    output logic        wall_found,
    output logic        last_row,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    grc_pkg::cfg_t cfg_reg;
    grc_pkg::cmd_t cmd;
    grc_pkg::sts_t sts;
    logic          wr_en;
    logic [2:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_rows    <= 7'd40;
            cfg_reg.screen_columns <= 8'd120;
            cfg_reg.field_of_view  <= 12'd1024;
            cfg_reg.march_step     <= 8'd26;
            cfg_reg.near_limit     <= 13'd1024;
            cfg_reg.middle_limit   <= 13'd1365;
            cfg_reg.far_limit      <= 13'd2048;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                grc_pkg::REG_ROWS:   cfg_reg.screen_rows    <= pwdata[6:0];
                grc_pkg::REG_COLS:   cfg_reg.screen_columns <= pwdata[7:0];
                grc_pkg::REG_FOV:    cfg_reg.field_of_view  <= pwdata[11:0];
                grc_pkg::REG_STEP:   cfg_reg.march_step     <= pwdata[7:0];
                grc_pkg::REG_NEAR:   cfg_reg.near_limit     <= pwdata[12:0];
                grc_pkg::REG_MIDDLE: cfg_reg.middle_limit   <= pwdata[12:0];
                grc_pkg::REG_FAR:    cfg_reg.far_limit      <= pwdata[12:0];
                default:             ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb
    begin
        unique case (reg_idx)
            grc_pkg::REG_ROWS:   prdata = {25'b0, cfg_reg.screen_rows};
            grc_pkg::REG_COLS:   prdata = {24'b0, cfg_reg.screen_columns};
            grc_pkg::REG_FOV:    prdata = {20'b0, cfg_reg.field_of_view};
            grc_pkg::REG_STEP:   prdata = {24'b0, cfg_reg.march_step};
            grc_pkg::REG_NEAR:   prdata = {19'b0, cfg_reg.near_limit};
            grc_pkg::REG_MIDDLE: prdata = {19'b0, cfg_reg.middle_limit};
            grc_pkg::REG_FAR:    prdata = {19'b0, cfg_reg.far_limit};
            default:             prdata = '0;
        endcase
    end

    grc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .command     (command),
        .shade_valid (shade_valid),
        .shade_ready (shade_ready),
        .cmd         (cmd),
        .sts         (sts)
    );

    grc_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg           (cfg_reg),
        .map_row       (map_row),
        .wall_bits     (wall_bits),
        .player_x      (player_x),
        .player_y      (player_y),
        .view_angle    (view_angle),
        .screen_column (screen_column),
        .row_number    (row_number),
        .shade_code    (shade_code),
        .ray_distance  (ray_distance),
        .wall_found    (wall_found),
        .last_row      (last_row)
    );

endmodule

// ----- design/grc_divider.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module grc_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [grc_pkg::DIV_NUM_W-1:0] dividend,
    input  logic [grc_pkg::DIV_DEN_W-1:0] divisor,
    output logic                          done,
    output logic [grc_pkg::DIV_NUM_W-1:0] quotient
);
    localparam int NW = grc_pkg::DIV_NUM_W;
    localparam int DW = grc_pkg::DIV_DEN_W;
    localparam int CW = grc_pkg::DIV_CNT_W;

    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [DW-1:0] rem_reg;
    logic [NW-1:0] quo_reg;
    logic [DW-1:0] den_reg;
    logic [DW:0]   rem_sh;
    logic [DW:0]   rem_sub;
    logic          fits;

    // Shift in the next dividend bit and try the subtract
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[NW-1]};
        fits    = rem_sh >= {1'b0, den_reg};
        rem_sub = fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
    end

    // Count the iterations and flag the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CW'(1));
            if (start)
            begin
                cnt_reg <= CW'(NW);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    // Hold the partial remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_sub[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- design/grc_datapath.sv -----
// Datapath: wall map, angle and trig, ray march, ceiling/floor and shade selection.
`timescale 1ns / 1ps
module grc_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  grc_pkg::cmd_t         cmd,
    output grc_pkg::sts_t         sts,
    input  grc_pkg::cfg_t         cfg,
    input  logic [3:0]            map_row,
    input  logic [15:0]           wall_bits,
    input  logic [15:0]           player_x,
    input  logic [15:0]           player_y,
    input  logic [11:0]           view_angle,
    input  logic [7:0]            screen_column,
    output logic [5:0]            row_number,
    output logic [3:0]            shade_code,
    output logic [12:0]           ray_distance,
    output logic                  wall_found,
    output logic                  last_row
);
    localparam grc_pkg::sine_tab_t SINE_TAB = grc_pkg::build_sine_tab();
    localparam int TB = grc_pkg::TRIG_BITS;
    localparam int TW = grc_pkg::TRIG_W;
    localparam int MB = grc_pkg::MAP_BITS;
    localparam int PF = grc_pkg::POS_FRAC;
    localparam int DW = grc_pkg::DIST_W;
    localparam int RW = grc_pkg::ROWS_W;
    localparam int YW = grc_pkg::ROW_W;
    localparam int NW = grc_pkg::DIV_NUM_W;
    localparam int EW = grc_pkg::DIV_DEN_W;

    // Map store
    logic [grc_pkg::MAP_SIDE-1:0] map_reg [grc_pkg::MAP_SIDE];

    // Per-cast registers
    logic [15:0]        px_reg;
    logic [15:0]        py_reg;
    logic [11:0]        view_reg;
    logic [NW-1:0]      prod_reg;
    logic [7:0]         cols_reg;
    logic [7:0]         step_reg;
    logic [RW-1:0]      rows_reg;
    logic [11:0]        ang_reg;
    logic signed [TW-1:0] sn_reg;
    logic signed [TW-1:0] cs_reg;
    logic signed [23:0] ix_reg;
    logic signed [23:0] iy_reg;
    logic signed [27:0] ax_reg;
    logic signed [27:0] ay_reg;
    logic [DW-1:0]      d_reg;
    logic               hit_reg;
    logic               neg_reg;
    logic               dzero_reg;
    logic [NW-1:0]      mag_reg;
    logic [EW-1:0]      den_reg;
    logic signed [16:0] ceil_reg;
    logic signed [17:0] floor_reg;
    logic [6:0]         fsat_reg;
    logic [YW-1:0]      y_reg;

    // Output beat registers
    logic [5:0]  row_number_reg;
    logic [3:0]  shade_code_reg;
    logic [12:0] ray_distance_reg;
    logic        wall_found_reg;
    logic        last_row_reg;

    // Divider hookup
    logic          div_done;
    logic [NW-1:0] quotient;
    logic [NW-1:0] div_num;
    logic [EW-1:0] div_den;

    assign div_num = cmd.div_ceil ? mag_reg : prod_reg;
    assign div_den = cmd.div_ceil ? den_reg : {{(EW-8){1'b0}}, cols_reg};

    grc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (quotient)
    );

    // Trig lookup and march position
    logic [TB-1:0]      sin_idx;
    logic [TB-1:0]      cos_idx;
    logic signed [19:0] sum_x;
    logic signed [19:0] sum_y;
    logic               in_map;
    logic [MB-1:0]      cx;
    logic [MB-1:0]      cy;
    logic               wall_here;
    logic               dist_done;

    always_comb
    begin
        sin_idx   = ang_reg[11 -: TB];
        cos_idx   = sin_idx + TB'(grc_pkg::TRIG_DEPTH / 4);
        sum_x     = $signed({4'b0, px_reg}) + $signed({{2{ax_reg[27]}}, ax_reg[27:10]});
        sum_y     = $signed({4'b0, py_reg}) + $signed({{2{ay_reg[27]}}, ay_reg[27:10]});
        in_map    = (sum_x[19:PF+MB] == '0) && (sum_y[19:PF+MB] == '0);
        cx        = sum_x[PF+MB-1:PF];
        cy        = sum_y[PF+MB-1:PF];
        wall_here = map_reg[cy][cx];
        dist_done = d_reg >= grc_pkg::MARCH_LIMIT;
    end

    // Ceiling from the quotient, floor from the ceiling
    logic signed [16:0] ceil_next;
    logic signed [17:0] floor_next;
    logic signed [21:0] num_full;
    logic signed [13:0] d_off;

    always_comb
    begin
        d_off = $signed({1'b0, d_reg}) - 14'sd512;
        num_full = $signed({15'b0, rows_reg}) * $signed({{8{d_off[13]}}, d_off});
        if (dzero_reg)
        begin
            ceil_next = -17'sd1;
        end
        else if (neg_reg)
        begin
            ceil_next = -$signed({1'b0, quotient[15:0]});
        end
        else
        begin
            ceil_next = $signed({1'b0, quotient[15:0]});
        end
        floor_next = $signed({11'b0, rows_reg}) - $signed({ceil_next[16], ceil_next});
    end

    // Shade for the current row
    logic signed [17:0] ys;
    logic signed [8:0]  y9;
    logic signed [8:0]  t4;
    logic signed [8:0]  t3;
    logic signed [8:0]  t2;
    logic [14:0]        f3_prod;
    logic [3:0]         shade;

    always_comb
    begin
        ys      = $signed({{(18-YW){1'b0}}, y_reg});
        y9      = $signed({{(9-YW){1'b0}}, y_reg});
        f3_prod = 15'(fsat_reg) * 15'd171;
        t4      = $signed({2'b0, rows_reg}) - $signed({4'b0, fsat_reg[6:2]});
        t3      = $signed({2'b0, rows_reg}) - $signed({3'b0, f3_prod[14:9]});
        t2      = $signed({2'b0, rows_reg}) - $signed({3'b0, fsat_reg[6:1]});
        shade   = grc_pkg::SHADE_BLANK;
        if ((ys > $signed({ceil_reg[16], ceil_reg})) && (ys <= floor_reg))
        begin
            if (d_reg <= cfg.near_limit)
                shade = grc_pkg::SHADE_FULL;
            else if (d_reg <= cfg.middle_limit)
                shade = grc_pkg::SHADE_DARK;
            else if (d_reg <= cfg.far_limit)
                shade = grc_pkg::SHADE_MEDIUM;
            else if (hit_reg)
                shade = grc_pkg::SHADE_LIGHT;
            else
                shade = grc_pkg::SHADE_BLANK;
        end
        else if (ys > floor_reg)
        begin
            if (y9 > t4)
                shade = grc_pkg::SHADE_PLUS;
            else if (y9 > t3)
                shade = grc_pkg::SHADE_EQUALS;
            else if (y9 > t2)
                shade = grc_pkg::SHADE_DASH;
            else
                shade = grc_pkg::SHADE_DOT;
        end
    end

    // Write map rows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < grc_pkg::MAP_SIDE; i++)
            begin
                map_reg[i] <= '0;
            end
        end
        else if (cmd.load_map)
        begin
            map_reg[map_row] <= wall_bits;
        end
    end

    // Work registers of one cast
    always_ff @(posedge clk)
    begin
        if (cmd.load_cast)
        begin
            px_reg   <= player_x;
            py_reg   <= player_y;
            view_reg <= view_angle;
            prod_reg <= NW'(screen_column) * NW'(cfg.field_of_view);
            cols_reg <= (cfg.screen_columns == '0) ? 8'd1 : cfg.screen_columns;
            step_reg <= (cfg.march_step == '0) ? 8'd1 : cfg.march_step;
            rows_reg <= (cfg.screen_rows > RW'(grc_pkg::MAX_ROWS)) ?
                        RW'(grc_pkg::MAX_ROWS) : cfg.screen_rows;
        end
        if (cmd.take_angle)
        begin
            ang_reg <= view_reg - {1'b0, cfg.field_of_view[11:1]} + quotient[11:0];
        end
        if (cmd.take_trig)
        begin
            sn_reg <= $signed(SINE_TAB[sin_idx*TW +: TW]);
            cs_reg <= $signed(SINE_TAB[cos_idx*TW +: TW]);
        end
        if (cmd.take_inc)
        begin
            ix_reg  <= $signed({{8{cs_reg[TW-1]}}, cs_reg}) * $signed({16'b0, step_reg});
            iy_reg  <= $signed({{8{sn_reg[TW-1]}}, sn_reg}) * $signed({16'b0, step_reg});
            ax_reg  <= '0;
            ay_reg  <= '0;
            d_reg   <= '0;
            hit_reg <= 1'b0;
        end
        else if (cmd.march_adv && !dist_done)
        begin
            if (!in_map)
            begin
                d_reg <= grc_pkg::MARCH_LIMIT;
            end
            else if (wall_here)
            begin
                hit_reg <= 1'b1;
            end
            else
            begin
                d_reg  <= d_reg + {5'b0, step_reg};
                ax_reg <= ax_reg + {{4{ix_reg[23]}}, ix_reg};
                ay_reg <= ay_reg + {{4{iy_reg[23]}}, iy_reg};
            end
        end
        if (cmd.take_num)
        begin
            neg_reg   <= num_full[21];
            mag_reg   <= num_full[21] ? NW'(-num_full) : NW'(num_full);
            den_reg   <= {d_reg, 1'b0};
            dzero_reg <= (d_reg == '0);
        end
        if (cmd.take_ceil)
        begin
            ceil_reg  <= ceil_next;
            floor_reg <= floor_next;
            fsat_reg  <= (floor_next > 18'sd127) ? 7'd127 : floor_next[6:0];
            y_reg     <= '0;
        end
        else if (cmd.emit)
        begin
            y_reg <= y_reg + YW'(1);
        end
    end

    // Load the output beat
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            row_number_reg   <= y_reg;
            shade_code_reg   <= shade;
            ray_distance_reg <= d_reg;
            wall_found_reg   <= hit_reg;
            last_row_reg     <= sts.row_last;
        end
    end

    always_comb
    begin
        sts.div_done   = div_done;
        sts.march_stop = dist_done || !in_map || wall_here;
        sts.rows_zero  = (rows_reg == '0);
        sts.row_last   = (({1'b0, y_reg} + RW'(1)) == rows_reg);
    end

    assign row_number   = row_number_reg;
    assign shade_code   = shade_code_reg;
    assign ray_distance = ray_distance_reg;
    assign wall_found   = wall_found_reg;
    assign last_row     = last_row_reg;

endmodule

// ----- design/grc_ctrl.sv -----
// Controller: sequences load, angle divide, march, ceiling divide and row emission.
`timescale 1ns / 1ps
module grc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_ready,
    input  logic          command,
    output logic          shade_valid,
    input  logic          shade_ready,
    output grc_pkg::cmd_t cmd,
    input  grc_pkg::sts_t sts
);
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_ADIV_GO   = 4'd1;
    localparam logic [3:0] S_ADIV_WAIT = 4'd2;
    localparam logic [3:0] S_TRIG      = 4'd3;
    localparam logic [3:0] S_INC       = 4'd4;
    localparam logic [3:0] S_MARCH     = 4'd5;
    localparam logic [3:0] S_CMUL      = 4'd6;
    localparam logic [3:0] S_CDIV_GO   = 4'd7;
    localparam logic [3:0] S_CDIV_WAIT = 4'd8;
    localparam logic [3:0] S_EMIT      = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;

    assign item_ready  = (state_reg == S_IDLE);
    assign accept      = item_valid && item_ready;
    assign shade_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (command == grc_pkg::CMD_CAST)
                    begin
                        cmd.load_cast = 1'b1;
                        state_next    = S_ADIV_GO;
                    end
                    else
                    begin
                        cmd.load_map = 1'b1;
                    end
                end
            end
            S_ADIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_ADIV_WAIT;
            end
            S_ADIV_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.take_angle = 1'b1;
                    state_next     = S_TRIG;
                end
            end
            S_TRIG:
            begin
                cmd.take_trig = 1'b1;
                state_next    = S_INC;
            end
            S_INC:
            begin
                cmd.take_inc = 1'b1;
                state_next   = S_MARCH;
            end
            S_MARCH:
            begin
                cmd.march_adv = 1'b1;
                if (sts.march_stop)
                begin
                    state_next = S_CMUL;
                end
            end
            S_CMUL:
            begin
                cmd.take_num = 1'b1;
                state_next   = sts.rows_zero ? S_IDLE : S_CDIV_GO;
            end
            S_CDIV_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_ceil  = 1'b1;
                state_next    = S_CDIV_WAIT;
            end
            S_CDIV_WAIT:
            begin
                cmd.div_ceil = 1'b1;
                if (sts.div_done)
                begin
                    cmd.take_ceil = 1'b1;
                    state_next    = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || shade_ready)
                begin
                    cmd.emit = 1'b1;
                    if (sts.row_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the output beat until taken
    always_comb
    begin
        priority if (cmd.emit)
            out_valid_next = 1'b1;
        else if (shade_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A new beat never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || shade_ready))
        else $error("beat overwritten while stalled");

    // A cast starts the angle divide next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command == grc_pkg::CMD_CAST) |=> (state_reg == S_ADIV_GO))
        else $error("cast did not start the angle divide");

    // Divider finishes only while waited for
    assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> (state_reg == S_ADIV_WAIT || state_reg == S_CDIV_WAIT))
        else $error("divider done outside a wait state");

endmodule

// ----- sim/grid_raycast_column_renderer_unit_tb.sv -----
// Self-checking testbench for the raycast column renderer: random casts, map loads and settings.
`timescale 1ns / 1ps
module grid_raycast_column_renderer_unit_tb;

    typedef struct packed {
        logic        command;
        logic [3:0]  map_row;
        logic [15:0] wall_bits;
        logic [15:0] player_x;
        logic [15:0] player_y;
        logic [11:0] view_angle;
        logic [7:0]  screen_column;
    } ray_item_t;

    typedef struct packed {
        logic [5:0]  row_number;
        logic [3:0]  shade_code;
        logic [12:0] ray_distance;
        logic        wall_found;
        logic        last_row;
    } shade_beat_t;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    logic        command;
    logic [3:0]  map_row;
    logic [15:0] wall_bits;
    logic [15:0] player_x;
    logic [15:0] player_y;
    logic [11:0] view_angle;
    logic [7:0]  screen_column;
    logic        shade_valid;
    logic        shade_ready;
    logic [5:0]  row_number;
    logic [3:0]  shade_code;
    logic [12:0] ray_distance;
    logic        wall_found;
    logic        last_row;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    grid_raycast_column_renderer_unit dut (.*);

    // Predictor state
    logic [15:0]    map_rows [grc_pkg::MAP_SIDE];
    grc_pkg::cfg_t  cfg_now;

    ray_item_t   pending_items [$];
    shade_beat_t expected_shades [$];
    int          mismatch_count;
    int          send_gap;
    int          recv_gap;
    bit          hold_items;

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // floor(v / 2^s) for signed values
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint sine_of_phase(longint ph);
        longint quad;
        longint r;
        longint z;
        longint z2;
        longint s;
        longint y;
        quad = (ph >> 14) & 3;
        r = ph & 16383;
        if (quad[0])
        begin
            r = 16384 - r;
        end
        z = r * 4;
        z2 = (z * z) >>> 16;
        s = 11;
        s = -307 + floor_shift(z2 * s, 16);
        s = 5223 + floor_shift(z2 * s, 16);
        s = -42334 + floor_shift(z2 * s, 16);
        s = 102944 + floor_shift(z2 * s, 16);
        y = floor_shift(z * s, 18);
        if (y > 16384) y = 16384;
        if (y < 0) y = 0;
        return quad[1] ? -y : y;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Work out the shade beats of one item and queue them
    task automatic render_column(ray_item_t it);
        longint cols;
        longint stp;
        longint ang;
        longint ph;
        longint sn;
        longint cs;
        longint ray_dist;
        longint cx;
        longint cy;
        longint rows;
        longint ceil_r;
        longint floor_r;
        longint yy;
        bit     hit;
        shade_beat_t b;
        if (it.command == grc_pkg::CMD_LOAD)
        begin
            map_rows[it.map_row] = it.wall_bits;
            return;
        end
        hit = 1'b0;
        cols = (cfg_now.screen_columns == 0) ? 1 : cfg_now.screen_columns;
        stp = (cfg_now.march_step == 0) ? 1 : cfg_now.march_step;
        ang = it.view_angle + 4096 - (cfg_now.field_of_view >> 1)
            + (longint'(it.screen_column) * cfg_now.field_of_view) / cols;
        ang = ang & 4095;
        ph = ((ang * grc_pkg::TRIG_DEPTH) >> 12) * (65536 / grc_pkg::TRIG_DEPTH);
        sn = sine_of_phase(ph & 65535);
        cs = sine_of_phase((ph + 16384) & 65535);
        for (ray_dist = 0; ray_dist < grc_pkg::MAP_SIDE * 256; ray_dist += stp)
        begin
            cx = floor_shift(longint'(it.player_x) + floor_shift(cs * ray_dist, 10), 12);
            cy = floor_shift(longint'(it.player_y) + floor_shift(sn * ray_dist, 10), 12);
            if (cx < 0 || cy < 0 || cx >= grc_pkg::MAP_SIDE || cy >= grc_pkg::MAP_SIDE)
            begin
                ray_dist = grc_pkg::MAP_SIDE * 256;
                break;
            end
            if (map_rows[cy][cx])
            begin
                hit = 1'b1;
                break;
            end
        end
        rows = (cfg_now.screen_rows > grc_pkg::MAX_ROWS) ? grc_pkg::MAX_ROWS
            : cfg_now.screen_rows;
        if (ray_dist == 0)
            ceil_r = -1;
        else
            ceil_r = (rows * ray_dist - 512 * rows) / (2 * ray_dist);
        floor_r = rows - ceil_r;
        for (yy = 0; yy < rows; yy++)
        begin
            b.shade_code = grc_pkg::SHADE_BLANK;
            if (yy > ceil_r && yy <= floor_r)
            begin
                if (ray_dist <= cfg_now.near_limit) b.shade_code = grc_pkg::SHADE_FULL;
                else if (ray_dist <= cfg_now.middle_limit) b.shade_code = grc_pkg::SHADE_DARK;
                else if (ray_dist <= cfg_now.far_limit) b.shade_code = grc_pkg::SHADE_MEDIUM;
                else if (hit) b.shade_code = grc_pkg::SHADE_LIGHT;
            end
            else if (yy > floor_r)
            begin
                if (yy > rows - floor_r / 4) b.shade_code = grc_pkg::SHADE_PLUS;
                else if (yy > rows - floor_r / 3) b.shade_code = grc_pkg::SHADE_EQUALS;
                else if (yy > rows - floor_r / 2) b.shade_code = grc_pkg::SHADE_DASH;
                else b.shade_code = grc_pkg::SHADE_DOT;
            end
            b.row_number = yy[5:0];
            b.ray_distance = ray_dist[12:0];
            b.wall_found = hit;
            b.last_row = (yy + 1 == rows);
            expected_shades.push_back(b);
        end
    endtask

    // Driver: present pending items with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                render_column(pending_items.pop_front());
            end
            if (item_valid && !item_ready)
            begin
                // hold the beat
            end
            else if (send_gap > 0)
            begin
                item_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_items.size() > 0 && !hold_items)
            begin
                item_valid <= 1'b1;
                {command, map_row, wall_bits, player_x, player_y, view_angle,
                    screen_column} <= pending_items[0];
                send_gap <= gap_len();
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each shade beat with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        shade_beat_t got;
        shade_beat_t want;
        if (!rst_n)
        begin
            shade_ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (shade_valid && shade_ready)
            begin
                got = '{row_number, shade_code, ray_distance, wall_found, last_row};
                if (expected_shades.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected beat row %0d shade %0d", row_number, shade_code);
                end
                else
                begin
                    want = expected_shades.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("beat mismatch: expected row %0d shade %0d ",
                                want.row_number, want.shade_code,
                                "dist %0d wall %0d last %0d, ",
                                want.ray_distance, want.wall_found, want.last_row,
                                "got row %0d shade %0d dist %0d wall %0d last %0d",
                                got.row_number, got.shade_code, got.ray_distance,
                                got.wall_found, got.last_row);
                    end
                end
            end
            if (recv_gap > 0)
            begin
                shade_ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else
            begin
                shade_ready <= 1'b1;
                recv_gap <= gap_len();
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            grc_pkg::REG_ROWS:   cfg_now.screen_rows = val[6:0];
            grc_pkg::REG_COLS:   cfg_now.screen_columns = val[7:0];
            grc_pkg::REG_FOV:    cfg_now.field_of_view = val[11:0];
            grc_pkg::REG_STEP:   cfg_now.march_step = val[7:0];
            grc_pkg::REG_NEAR:   cfg_now.near_limit = val[12:0];
            grc_pkg::REG_MIDDLE: cfg_now.middle_limit = val[12:0];
            default:             cfg_now.far_limit = val[12:0];
        endcase
    endtask

    // Wait until no item is pending, in work or owed a beat
    task automatic wait_idle();
        while (pending_items.size() > 0 || item_valid || expected_shades.size() > 0
               || !item_ready || shade_valid)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic ray_item_t load_item(logic [3:0] r, logic [15:0] w);
        ray_item_t it;
        it = '0;
        it.command = grc_pkg::CMD_LOAD;
        it.map_row = r;
        it.wall_bits = w;
        return it;
    endfunction

    function automatic ray_item_t cast_item(logic [15:0] x, logic [15:0] y,
                                           logic [11:0] a, logic [7:0] c);
        ray_item_t it;
        it = '0;
        it.command = grc_pkg::CMD_CAST;
        it.map_row = 4'($urandom);
        it.wall_bits = 16'($urandom);
        it.player_x = x;
        it.player_y = y;
        it.view_angle = a;
        it.screen_column = c;
        return it;
    endfunction

    // Random cast: most from anywhere in the map, the rest on its left or right edge
    function automatic ray_item_t random_cast();
        if ($urandom_range(0, 9) < 8)
            return cast_item(16'($urandom), 16'($urandom), 12'($urandom),
                8'($urandom_range(0, 130)));
        return cast_item($urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom),
            12'($urandom), 8'($urandom));
    endfunction

    function automatic logic [15:0] border_row(int r);
        if (r == 0 || r == 15) return 16'hFFFF;
        return 16'h8001 | (($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0);
    endfunction

    initial
    begin
        int ph;
        int i;
        logic [31:0] cfg_set [7];
        rst_n = 1'b0;
        item_valid = 1'b0;
        command = 1'b0;
        map_row = '0;
        wall_bits = '0;
        player_x = '0;
        player_y = '0;
        view_angle = '0;
        screen_column = '0;
        shade_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatch_count = 0;
        hold_items = 1'b0;
        for (i = 0; i < grc_pkg::MAP_SIDE; i++) map_rows[i] = '0;
        cfg_now = '{7'd40, 8'd120, 12'd1024, 8'd26, 13'd1024, 13'd1365, 13'd2048};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty map, extremes, zero distance, loads
        pending_items.push_back(cast_item(16'h8000, 16'h8000, 12'd0, 8'd0));
        pending_items.push_back(cast_item(16'hFFFF, 16'hFFFF, 12'hFFF, 8'hFF));
        pending_items.push_back(cast_item(16'h0000, 16'h0000, 12'd2048, 8'd60));
        pending_items.push_back(load_item(4'd8, 16'hFFFF));
        pending_items.push_back(cast_item(16'h8800, 16'h8800, 12'd0, 8'd60));
        pending_items.push_back(cast_item(16'h4000, 16'h4000, 12'd1024, 8'd60));
        pending_items.push_back(load_item(4'd15, 16'h5555));
        pending_items.push_back(load_item(4'd0, 16'hAAAA));
        pending_items.push_back(cast_item(16'h1000, 16'h0800, 12'd3072, 8'd119));
        for (i = 0; i < 16; i++) pending_items.push_back(load_item(4'(i), border_row(i)));
        wait_idle();

        // Phases of settings, extremes included
        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: cfg_set = '{64, 255, 4095, 255, 4096, 4096, 4096};
                1: cfg_set = '{1, 1, 0, 1, 0, 0, 0};
                2: cfg_set = '{0, 0, 512, 0, 300, 600, 900};
                3: cfg_set = '{127, 7, 2048, 128, 512, 1024, 1536};
                default: cfg_set = '{$urandom_range(1, 70), $urandom_range(0, 255),
                    $urandom_range(0, 4095), $urandom_range(8, 255),
                    $urandom_range(0, 4096), $urandom_range(0, 4096),
                    $urandom_range(0, 4096)};
            endcase
            for (i = 0; i < 7; i++) write_reg(3'(i), cfg_set[i]);
            for (i = 0; i < 58; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    pending_items.push_back(load_item(4'($urandom), $urandom_range(0, 1)
                        ? border_row($urandom_range(0, 15)) : 16'($urandom)));
                else
                    pending_items.push_back(random_cast());
            end
            if (ph == 4)
            begin
                // pause the sender until every beat has come
                while (pending_items.size() > 20) @(posedge clk);
                hold_items = 1'b1;
                while (item_valid || expected_shades.size() > 0) @(posedge clk);
                hold_items = 1'b0;
            end
            wait_idle();
        end
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
